// ===== rtl/script_source_tokenizer_macros.svh =====
`ifndef SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_MACROS_SVH

// same-cycle implication, checking off while reset is held
`define SST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking off while reset is held
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
package sst_pkg;

    localparam int KIND_W   = 4;
    localparam int START_W  = 16;
    localparam int LENGTH_W = 11;

    typedef enum logic [KIND_W-1:0] {
        TOK_KEYWORD  = 4'd0,
        TOK_IDENT    = 4'd1,
        TOK_DOT      = 4'd2,
        TOK_LPAREN   = 4'd3,
        TOK_RPAREN   = 4'd4,
        TOK_LBRACE   = 4'd5,
        TOK_RBRACE   = 4'd6,
        TOK_SEMI     = 4'd7,
        TOK_EQ       = 4'd8,
        TOK_EQEQ     = 4'd9,
        TOK_STRING   = 4'd10,
        TOK_NEWLINE  = 4'd11,
        TOK_NUMBER   = 4'd12,
        TOK_BAD_CHAR = 4'd13,
        TOK_TWO_DOTS = 4'd14,
        TOK_TOO_LONG = 4'd15
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_STRING = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_EQ     = 3'd4,
        MODE_HALT   = 3'd5
    } lex_mode_t;

    typedef struct packed {
        token_kind_t         kind;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } token_t;

    // tokens produced by one character, in order; count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_pair_t;

endpackage

// ===== rtl/sst_if.sv =====
interface sst_char_if
    import sst_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface sst_token_if
    import sst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   token_kind;
    logic [START_W-1:0]  start_pos;
    logic [LENGTH_W-1:0] length;
    logic                last_of_run;

    modport source (
        output valid, output token_kind, output start_pos, output length,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input start_pos, input length,
        input last_of_run, output ready
    );
endinterface

// ===== rtl/sst_lexer.sv =====
`include "script_source_tokenizer_macros.svh"

module sst_lexer
    import sst_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 1024,
    parameter int POS_BITS      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output token_pair_t pair
);

    localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_TOKEN_LEN);
    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);

    // keyword prefix tracker codes
    localparam logic [2:0] KW_NONE  = 3'd0;
    localparam logic [2:0] KW_I     = 3'd1;
    localparam logic [2:0] KW_IF    = 3'd2;
    localparam logic [2:0] KW_C     = 3'd3;
    localparam logic [2:0] KW_CO    = 3'd4;
    localparam logic [2:0] KW_CON   = 3'd5;
    localparam logic [2:0] KW_CONS  = 3'd6;
    localparam logic [2:0] KW_CONST = 3'd7;

    typedef enum logic [3:0] {
        CLS_ALPHA,
        CLS_DIGIT,
        CLS_DOT,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_SEMI,
        CLS_NEWLINE,
        CLS_QUOTE,
        CLS_EQUAL,
        CLS_SPACE,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        logic                valid;
        token_kind_t         kind;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] len;
    } raw_token_t;

    function automatic char_class_t classify(logic [7:0] c);
        char_class_t cls;
        if (c inside {["a":"z"], ["A":"Z"]}) cls = CLS_ALPHA;
        else if (c inside {["0":"9"]}) cls = CLS_DIGIT;
        else if (c inside {" ", "\t"}) cls = CLS_SPACE;
        else begin
            case (c)
                ".":     cls = CLS_DOT;
                "(":     cls = CLS_LPAREN;
                ")":     cls = CLS_RPAREN;
                "{":     cls = CLS_LBRACE;
                "}":     cls = CLS_RBRACE;
                ";":     cls = CLS_SEMI;
                "\n":    cls = CLS_NEWLINE;
                "\"":    cls = CLS_QUOTE;
                "=":     cls = CLS_EQUAL;
                default: cls = CLS_BAD;
            endcase
        end
        return cls;
    endfunction

    function automatic logic [2:0] kw_first(logic [7:0] c);
        logic [2:0] m;
        case (c)
            "i":     m = KW_I;
            "c":     m = KW_C;
            default: m = KW_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] kw_next(logic [2:0] m, logic [7:0] c);
        logic [2:0] n;
        n = KW_NONE;
        if (m == KW_I && c == "f") n = KW_IF;
        if (m == KW_C && c == "o") n = KW_CO;
        if (m == KW_CO && c == "n") n = KW_CON;
        if (m == KW_CON && c == "s") n = KW_CONS;
        if (m == KW_CONS && c == "t") n = KW_CONST;
        return n;
    endfunction

    function automatic token_kind_t ident_kind(logic [2:0] m);
        return (m == KW_IF || m == KW_CONST) ? TOK_KEYWORD : TOK_IDENT;
    endfunction

    function automatic token_t to_token(raw_token_t r, logic last);
        token_t t;
        t.kind   = r.kind;
        t.start  = START_W'(r.start);
        t.length = LENGTH_W'(r.len);
        t.last   = last;
        return t;
    endfunction

    lex_mode_t           mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic                dot_reg, dot_next;
    logic [2:0]          kw_reg, kw_next_val;

    char_class_t         cls;
    logic                at_limit;
    logic [LEN_BITS-1:0] len_inc;

    // after the current mode has handled the character
    lex_mode_t           mode_mid;
    logic [POS_BITS-1:0] start_mid;
    logic [LEN_BITS-1:0] len_mid;
    logic                dot_mid;
    logic [2:0]          kw_mid;
    logic                run_idle;

    // after the idle-mode pass, before the end-of-text flush
    lex_mode_t           mode_fin;
    logic [POS_BITS-1:0] start_fin;
    logic [LEN_BITS-1:0] len_fin;
    logic                dot_fin;
    logic [2:0]          kw_fin;

    raw_token_t          tok_a, tok_b, tok_c;

    assign cls      = classify(ch);
    assign at_limit = (len_reg >= MAX_LEN);
    assign len_inc  = LEN_BITS'(len_reg + 1'b1);

    // current mode consumes the character or hands it to idle handling
    always_comb
    begin
        mode_mid    = mode_reg;
        start_mid   = start_reg;
        len_mid     = len_reg;
        dot_mid     = dot_reg;
        kw_mid      = kw_reg;
        run_idle    = 1'b0;
        tok_a.valid = 1'b0;
        tok_a.kind  = TOK_IDENT;
        tok_a.start = start_reg;
        tok_a.len   = len_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                run_idle = 1'b1;
            end
            MODE_IDENT:
            begin
                if (cls == CLS_ALPHA) begin
                    if (at_limit) begin
                        tok_a.valid = 1'b1;
                        tok_a.kind  = TOK_TOO_LONG;
                        tok_a.len   = MAX_LEN;
                        mode_mid    = MODE_HALT;
                    end else begin
                        len_mid = len_inc;
                        kw_mid  = kw_next(kw_reg, ch);
                    end
                end else begin
                    tok_a.valid = 1'b1;
                    tok_a.kind  = ident_kind(kw_reg);
                    mode_mid    = MODE_IDLE;
                    run_idle    = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (cls == CLS_QUOTE) begin
                    tok_a.valid = 1'b1;
                    tok_a.kind  = TOK_STRING;
                    mode_mid    = MODE_IDLE;
                end else if (at_limit) begin
                    tok_a.valid = 1'b1;
                    tok_a.kind  = TOK_TOO_LONG;
                    tok_a.len   = MAX_LEN;
                    mode_mid    = MODE_HALT;
                end else begin
                    len_mid = len_inc;
                end
            end
            MODE_NUMBER:
            begin
                if (cls == CLS_DIGIT || (cls == CLS_DOT && !dot_reg)) begin
                    if (at_limit) begin
                        tok_a.valid = 1'b1;
                        tok_a.kind  = TOK_TOO_LONG;
                        tok_a.len   = MAX_LEN;
                        mode_mid    = MODE_HALT;
                    end else begin
                        len_mid = len_inc;
                        dot_mid = dot_reg | (cls == CLS_DOT);
                    end
                end else if (cls == CLS_DOT) begin
                    tok_a.valid = 1'b1;
                    tok_a.kind  = TOK_TWO_DOTS;
                    mode_mid    = MODE_HALT;
                end else begin
                    tok_a.valid = 1'b1;
                    tok_a.kind  = TOK_NUMBER;
                    mode_mid    = MODE_IDLE;
                    run_idle    = 1'b1;
                end
            end
            MODE_EQ:
            begin
                tok_a.valid = 1'b1;
                mode_mid    = MODE_IDLE;
                if (cls == CLS_EQUAL) begin
                    tok_a.kind = TOK_EQEQ;
                    tok_a.len  = LEN_TWO;
                end else begin
                    tok_a.kind = TOK_EQ;
                    tok_a.len  = LEN_ONE;
                    run_idle   = 1'b1;
                end
            end
            default:
            begin
                // halted: characters are dropped until end of text
            end
        endcase
    end

    // idle-mode handling of the character
    always_comb
    begin
        mode_fin    = mode_mid;
        start_fin   = start_mid;
        len_fin     = len_mid;
        dot_fin     = dot_mid;
        kw_fin      = kw_mid;
        tok_b.valid = 1'b0;
        tok_b.kind  = TOK_BAD_CHAR;
        tok_b.start = pos_reg;
        tok_b.len   = LEN_ONE;
        if (run_idle) begin
            case (cls)
                CLS_ALPHA:
                begin
                    mode_fin  = MODE_IDENT;
                    start_fin = pos_reg;
                    len_fin   = LEN_ONE;
                    dot_fin   = 1'b0;
                    kw_fin    = kw_first(ch);
                end
                CLS_DIGIT:
                begin
                    mode_fin  = MODE_NUMBER;
                    start_fin = pos_reg;
                    len_fin   = LEN_ONE;
                    dot_fin   = 1'b0;
                    kw_fin    = KW_NONE;
                end
                CLS_QUOTE:
                begin
                    // string start points past the opening quote
                    mode_fin  = MODE_STRING;
                    start_fin = POS_BITS'(pos_reg + 1'b1);
                    len_fin   = '0;
                    dot_fin   = 1'b0;
                    kw_fin    = KW_NONE;
                end
                CLS_EQUAL:
                begin
                    mode_fin  = MODE_EQ;
                    start_fin = pos_reg;
                    len_fin   = LEN_ONE;
                    dot_fin   = 1'b0;
                    kw_fin    = KW_NONE;
                end
                CLS_DOT:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_DOT;
                end
                CLS_LPAREN:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_LPAREN;
                end
                CLS_RPAREN:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_RPAREN;
                end
                CLS_LBRACE:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_LBRACE;
                end
                CLS_RBRACE:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_RBRACE;
                end
                CLS_SEMI:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_SEMI;
                end
                CLS_NEWLINE:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_NEWLINE;
                end
                CLS_SPACE:
                begin
                end
                default:
                begin
                    tok_b.valid = 1'b1;
                    tok_b.kind  = TOK_BAD_CHAR;
                    mode_fin    = MODE_HALT;
                end
            endcase
        end
    end

    // end-of-text flush and next state
    always_comb
    begin
        tok_c.valid = 1'b0;
        tok_c.kind  = TOK_NUMBER;
        tok_c.start = start_fin;
        tok_c.len   = len_fin;
        if (end_of_text) begin
            case (mode_fin)
                MODE_IDENT:
                begin
                    tok_c.valid = 1'b1;
                    tok_c.kind  = ident_kind(kw_fin);
                end
                MODE_NUMBER:
                begin
                    tok_c.valid = 1'b1;
                end
                MODE_EQ:
                begin
                    tok_c.valid = 1'b1;
                    tok_c.kind  = TOK_EQ;
                    tok_c.len   = LEN_ONE;
                end
                default:
                begin
                    // unterminated string or halt ends silently
                end
            endcase
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            start_next  = '0;
            len_next    = '0;
            dot_next    = 1'b0;
            kw_next_val = KW_NONE;
        end else begin
            mode_next   = mode_fin;
            pos_next    = POS_BITS'(pos_reg + 1'b1);
            start_next  = start_fin;
            len_next    = len_fin;
            dot_next    = dot_fin;
            kw_next_val = kw_fin;
        end
    end

    // pack up to two tokens in order
    always_comb
    begin
        pair.count  = '0;
        pair.first  = to_token(tok_c, 1'b1);
        pair.second = to_token(tok_c, 1'b1);
        if (accept) begin
            pair.count = 2'(tok_a.valid) + 2'(tok_b.valid) + 2'(tok_c.valid);
        end
        if (tok_a.valid) begin
            pair.first = to_token(tok_a, !(tok_b.valid || tok_c.valid));
            if (tok_b.valid) pair.second = to_token(tok_b, 1'b1);
        end else if (tok_b.valid) begin
            pair.first = to_token(tok_b, !tok_c.valid);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            dot_reg   <= 1'b0;
            kw_reg    <= KW_NONE;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            dot_reg   <= dot_next;
            kw_reg    <= kw_next_val;
        end
    end

    `SST_ASSERT_NEXT(eot_restarts_text, clk, rst_n, accept && end_of_text,
        pos_reg == '0 && mode_reg == MODE_IDLE && len_reg == '0, "text did not restart")
    `SST_ASSERT_NOW(halt_is_silent, clk, rst_n, accept && mode_reg == MODE_HALT,
        pair.count == 2'd0, "token emitted while halted")
    `SST_ASSERT_NOW(at_most_two_tokens, clk, rst_n, 1'b1,
        !(tok_a.valid && tok_b.valid && tok_c.valid), "three tokens from one character")

endmodule

// ===== rtl/sst_token_queue.sv =====
`include "script_source_tokenizer_macros.svh"

module sst_token_queue
    import sst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  token_pair_t push,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output token_t      out_token
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_plus;
    logic               pop;

    // room for a full pair keeps the input side free of the output stall
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_token = entry_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign wr_plus   = PTR_W'(wr_reg + 1'b1);

    assign wr_next    = PTR_W'(wr_reg + PTR_W'(push.count));
    assign rd_next    = PTR_W'(rd_reg + PTR_W'(pop));
    assign count_next = CNT_W'(count_reg + CNT_W'(push.count) - CNT_W'(pop));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) entry_reg[wr_reg] <= push.first;
        if (push.count == 2'd2) entry_reg[wr_plus] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `SST_ASSERT_NOW(push_needs_room, clk, rst_n, push.count != 2'd0, room,
        "tokens pushed without room")
    `SST_ASSERT_NOW(count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "queue count overflow")
    `SST_ASSERT_NEXT(empty_stays_empty, clk, rst_n,
        count_reg == '0 && push.count == 2'd0, !out_valid, "token appeared from nowhere")

endmodule

// ===== rtl/script_source_tokenizer.sv =====
// output: a token is offered on the output in the cycle after its character transfer,
//   when no earlier token is still waiting in the queue
// throughput: one character per cycle; a character that yields two tokens goes into a
//   four-entry token queue, and the input is held off while fewer than two entries are free
// reset: rst_n clears lexer state, position and queue; the first text starts at 0
module script_source_tokenizer
    import sst_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 1024,
    parameter int POS_BITS      = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    sst_char_if.sink     chars,
    sst_token_if.source  tokens
);

    token_pair_t pair;
    token_t      head;
    logic        room;
    logic        accept;

    assign chars.ready = room;
    assign accept      = chars.valid && room;

    sst_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POS_BITS      (POS_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ch          (chars.ch),
        .end_of_text (chars.end_of_text),
        .pair        (pair)
    );

    sst_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pair),
        .room      (room),
        .out_valid (tokens.valid),
        .out_ready (tokens.ready),
        .out_token (head)
    );

    assign tokens.token_kind  = head.kind;
    assign tokens.start_pos   = head.start;
    assign tokens.length      = head.length;
    assign tokens.last_of_run = head.last;

endmodule
